@@ rtl/arp_resolution_engine_macros.svh @@
// ============================================================================
// ARP resolution engine assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ============================================================================
`ifndef ARP_RESOLUTION_ENGINE_MACROS_SVH
`define ARP_RESOLUTION_ENGINE_MACROS_SVH

// same-cycle implication
`define ARE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ARE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/are_pkg.sv @@
// ============================================================================
// ARP resolution engine package
// Shared codes, item layouts and controller/datapath interface types.
// ============================================================================
package are_pkg;

    localparam int ITEM_W = 328;
    localparam int RES_W  = 144;
    localparam int CFG_W  = 48;

    localparam logic [1:0] ACT_SEND = 2'd0;
    localparam logic [1:0] ACT_RECV = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    localparam logic [2:0] KIND_IPV4      = 3'd0;
    localparam logic [2:0] KIND_ARP_REQ   = 3'd1;
    localparam logic [2:0] KIND_ARP_REPLY = 3'd2;
    localparam logic [2:0] KIND_DELIVER   = 3'd3;
    localparam logic [2:0] KIND_DROP      = 3'd4;

    localparam logic [1:0] REG_OWN_MAC  = 2'd0;
    localparam logic [1:0] REG_OWN_IP   = 2'd1;
    localparam logic [1:0] REG_LIFETIME = 2'd2;
    localparam logic [1:0] REG_HOLDOFF  = 2'd3;

    localparam logic [15:0] ET_IPV4    = 16'h0800;
    localparam logic [15:0] ET_ARP     = 16'h0806;
    localparam logic [15:0] OP_REQUEST = 16'd1;
    localparam logic [15:0] OP_REPLY   = 16'd2;
    localparam logic [47:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [6:0]  pad;
        logic [31:0] elapsed_ms;
        logic [31:0] target_ip;
        logic [47:0] target_mac;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [15:0] arp_opcode;
        logic        parse_ok;
        logic [15:0] ether_type;
        logic [47:0] frame_dst_mac;
        logic [15:0] datagram_tag;
        logic [31:0] gw_ip;
    } t_item;

    typedef struct packed {
        logic [31:0] reply_target_ip;
        logic [47:0] reply_target_mac;
        logic [15:0] out_tag;
        logic [47:0] dst_mac;
    } t_res_data;

    typedef struct packed {
        logic [2:0] kind;
        t_res_data  data;
    } t_result;

    typedef enum logic [1:0] {
        KEY_NHIP,
        KEY_SIP,
        KEY_TIP
    } t_key_sel;

    typedef struct packed {
        logic     capture;
        logic     tick_add;
        logic     scan_rd;
        logic     scan_expire;
        t_key_sel key_sel;
        logic     act_send;
        logic     act_learn;
        logic     push_deliver;
        logic     push_reply;
        logic     out_pop;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       rx_drop;
        logic       rx_ipv4;
        logic       op_reply;
        logic       op_request;
        logic       tip_own;
        logic [1:0] res_cnt;
        logic       out_last;
    } t_dp_sts;

endpackage

@@ rtl/are_dp.sv @@
// ============================================================================
// ARP resolution engine datapath
// Config registers, time, cache/pending/request tables, scan compare and
// result buffer.
// ============================================================================
module are_dp #(
    parameter int CACHE_ENTRIES   = 16,
    parameter int PENDING_ENTRIES = 16,
    parameter int REQUEST_ENTRIES = 16,
    parameter int TAG_BITS        = 16,
    parameter int IW              = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [1:0]               i_cfg_index,
    input  logic [are_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic [are_pkg::ITEM_W-1:0] i_item_data,
    input  logic [1:0]               i_item_action,
    input  are_pkg::t_dp_cmd         i_cmd,
    input  logic [IW-1:0]            i_scan_addr,
    output are_pkg::t_dp_sts         o_sts,
    output logic [are_pkg::RES_W-1:0] o_res_data,
    output logic [2:0]               o_res_kind
);
    import are_pkg::*;

    localparam int CIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int PIW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int RIW = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [63:0] expiry;
    } t_centry;

    typedef struct packed {
        logic [31:0]         ip;
        logic [TAG_BITS-1:0] tag;
    } t_pentry;

    typedef struct packed {
        logic [31:0] ip;
        logic [63:0] expiry;
    } t_rentry;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [31:0] b);
        logic [64:0] s;
        s = {1'b0, a} + 65'(b);
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [15:0] tag16(input logic [TAG_BITS-1:0] t);
        logic [31:0] w;
        w = 32'(t);
        return w[15:0];
    endfunction

    function automatic t_result mk_res(input logic [2:0] kind, input logic [47:0] dst,
                                       input logic [15:0] tag, input logic [47:0] tmac,
                                       input logic [31:0] tip);
        t_result r;
        r.kind                  = kind;
        r.data.dst_mac          = dst;
        r.data.out_tag          = tag;
        r.data.reply_target_mac = tmac;
        r.data.reply_target_ip  = tip;
        return r;
    endfunction

    logic [47:0] r_own_mac;
    logic [31:0] r_own_ip;
    logic [31:0] r_life;
    logic [31:0] r_hold;
    logic [63:0] r_now;

    t_item       r_item;
    logic [1:0]  r_action;

    t_centry     r_cmem [CACHE_ENTRIES];
    t_pentry     r_pmem [PENDING_ENTRIES];
    t_rentry     r_rmem [REQUEST_ENTRIES];
    t_centry     r_crd;
    t_pentry     r_prd;
    t_rentry     r_rrd;

    logic [CACHE_ENTRIES-1:0]   r_cv;
    logic [PENDING_ENTRIES-1:0] r_pv;
    logic [REQUEST_ENTRIES-1:0] r_rv;

    logic           r_e_vld;
    logic           r_e_exp;
    logic [IW-1:0]  r_e_idx;

    logic           r_c_hit;
    logic [CIW-1:0] r_c_hit_idx;
    logic [47:0]    r_c_mac;
    logic           r_c_free;
    logic [CIW-1:0] r_c_free_idx;
    logic [CIW-1:0] r_c_min_idx;
    logic [63:0]    r_c_min_exp;
    logic           r_p_hit;
    logic [PIW-1:0] r_p_hit_idx;
    logic [TAG_BITS-1:0] r_p_tag;
    logic           r_p_free;
    logic [PIW-1:0] r_p_free_idx;
    logic           r_r_hit;
    logic           r_r_free;
    logic [RIW-1:0] r_r_free_idx;

    t_result        r_res [2];
    logic [1:0]     r_res_cnt;
    logic           r_rd_ptr;

    logic [31:0]         key;
    logic [47:0]         lmac;
    logic [31:0]         tag_in32;
    logic [TAG_BITS-1:0] tag_st;
    logic                e_in_c;
    logic                e_in_p;
    logic                e_in_r;
    logic [CIW-1:0]      e_ci;
    logic [PIW-1:0]      e_pi;
    logic [RIW-1:0]      e_ri;
    logic [CIW-1:0]      c_slot;
    logic [PIW-1:0]      p_slot;
    logic                p_ok;
    logic                for_us;
    t_result             res_drop;
    t_result             res_req;

    always_comb begin
        case (i_cmd.key_sel)
            KEY_SIP: key = r_item.sender_ip;
            KEY_TIP: key = r_item.target_ip;
            default: key = r_item.gw_ip;
        endcase
    end

    assign lmac     = (i_cmd.key_sel == KEY_TIP) ? r_item.target_mac : r_item.sender_mac;
    assign tag_in32 = {16'd0, r_item.datagram_tag};
    assign tag_st   = tag_in32[TAG_BITS-1:0];

    assign e_in_c = 32'(r_e_idx) < 32'(CACHE_ENTRIES);
    assign e_in_p = 32'(r_e_idx) < 32'(PENDING_ENTRIES);
    assign e_in_r = 32'(r_e_idx) < 32'(REQUEST_ENTRIES);
    assign e_ci   = r_e_idx[CIW-1:0];
    assign e_pi   = r_e_idx[PIW-1:0];
    assign e_ri   = r_e_idx[RIW-1:0];

    assign c_slot = r_c_hit ? r_c_hit_idx : (r_c_free ? r_c_free_idx : r_c_min_idx);
    assign p_slot = r_p_hit ? r_p_hit_idx : r_p_free_idx;
    assign p_ok   = r_p_hit || r_p_free;

    assign res_drop = mk_res(KIND_DROP, 48'd0, tag16(tag_st), 48'd0, key);
    assign res_req  = mk_res(KIND_ARP_REQ, MAC_BCAST, 16'd0, 48'd0, key);

    assign for_us = (r_item.frame_dst_mac == r_own_mac) || (r_item.frame_dst_mac == MAC_BCAST);

    always_comb begin
        o_sts.action     = r_action;
        o_sts.rx_drop    = !for_us || !r_item.parse_ok ||
                           ((r_item.ether_type != ET_IPV4) && (r_item.ether_type != ET_ARP));
        o_sts.rx_ipv4    = r_item.ether_type == ET_IPV4;
        o_sts.op_reply   = r_item.arp_opcode == OP_REPLY;
        o_sts.op_request = r_item.arp_opcode == OP_REQUEST;
        o_sts.tip_own    = r_item.target_ip == r_own_ip;
        o_sts.res_cnt    = r_res_cnt;
        o_sts.out_last   = (2'(r_rd_ptr) + 2'd1) == r_res_cnt;
    end

    assign o_res_data = r_res[r_rd_ptr].data;
    assign o_res_kind = r_res[r_rd_ptr].kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
            r_own_ip  <= '0;
            r_life    <= 32'd30000;
            r_hold    <= 32'd5000;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_OWN_MAC:  r_own_mac <= i_cfg_wdata;
                REG_OWN_IP:   r_own_ip  <= i_cfg_wdata[31:0];
                REG_LIFETIME: r_life    <= i_cfg_wdata[31:0];
                REG_HOLDOFF:  r_hold    <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0;
        end else if (i_cmd.tick_add) begin
            r_now <= sat_add(r_now, r_item.elapsed_ms);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item   <= t_item'(i_item_data);
            r_action <= i_item_action;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_crd <= r_cmem[i_scan_addr[CIW-1:0]];
            r_prd <= r_pmem[i_scan_addr[PIW-1:0]];
            r_rrd <= r_rmem[i_scan_addr[RIW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act_learn) begin
            r_cmem[c_slot] <= '{ip: key, mac: lmac, expiry: sat_add(r_now, r_life)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act_send && !r_c_hit && p_ok) begin
            r_pmem[p_slot] <= '{ip: key, tag: tag_st};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.act_send && !r_c_hit && !r_r_hit && r_r_free) begin
            r_rmem[r_r_free_idx] <= '{ip: key, expiry: sat_add(r_now, r_hold)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_e_exp <= 1'b0;
        end else begin
            r_e_vld <= i_cmd.scan_rd;
            r_e_exp <= i_cmd.scan_expire;
        end
        r_e_idx <= i_scan_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_hit  <= 1'b0;
            r_c_free <= 1'b0;
            r_p_hit  <= 1'b0;
            r_p_free <= 1'b0;
            r_r_hit  <= 1'b0;
            r_r_free <= 1'b0;
        end else if (i_cmd.scan_rd && (i_scan_addr == '0)) begin
            r_c_hit  <= 1'b0;
            r_c_free <= 1'b0;
            r_p_hit  <= 1'b0;
            r_p_free <= 1'b0;
            r_r_hit  <= 1'b0;
            r_r_free <= 1'b0;
        end else if (r_e_vld) begin
            if (e_in_c) begin
                if (r_cv[e_ci] && (r_crd.ip == key) && !r_c_hit) begin
                    r_c_hit     <= 1'b1;
                    r_c_hit_idx <= e_ci;
                    r_c_mac     <= r_crd.mac;
                end
                if (!r_cv[e_ci] && !r_c_free) begin
                    r_c_free     <= 1'b1;
                    r_c_free_idx <= e_ci;
                end
                if ((e_ci == '0) || (r_crd.expiry < r_c_min_exp)) begin
                    r_c_min_idx <= e_ci;
                    r_c_min_exp <= r_crd.expiry;
                end
            end
            if (e_in_p) begin
                if (r_pv[e_pi] && (r_prd.ip == key) && !r_p_hit) begin
                    r_p_hit     <= 1'b1;
                    r_p_hit_idx <= e_pi;
                    r_p_tag     <= r_prd.tag;
                end
                if (!r_pv[e_pi] && !r_p_free) begin
                    r_p_free     <= 1'b1;
                    r_p_free_idx <= e_pi;
                end
            end
            if (e_in_r) begin
                if (r_rv[e_ri] && (r_rrd.ip == key)) begin
                    r_r_hit <= 1'b1;
                end
                if (!r_rv[e_ri] && !r_r_free) begin
                    r_r_free     <= 1'b1;
                    r_r_free_idx <= e_ri;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
            r_pv <= '0;
            r_rv <= '0;
        end else begin
            if (r_e_vld && r_e_exp) begin
                if (e_in_c && r_cv[e_ci] && (r_crd.expiry <= r_now)) begin
                    r_cv[e_ci] <= 1'b0;
                end
                if (e_in_r && r_rv[e_ri] && (r_rrd.expiry <= r_now)) begin
                    r_rv[e_ri] <= 1'b0;
                end
            end
            if (i_cmd.act_learn) begin
                r_cv[c_slot] <= 1'b1;
                if (r_p_hit) begin
                    r_pv[r_p_hit_idx] <= 1'b0;
                end
            end
            if (i_cmd.act_send && !r_c_hit) begin
                if (p_ok) begin
                    r_pv[p_slot] <= 1'b1;
                end
                if (!r_r_hit && r_r_free) begin
                    r_rv[r_r_free_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt <= '0;
            r_rd_ptr  <= 1'b0;
        end else if (i_cmd.capture) begin
            r_res_cnt <= '0;
            r_rd_ptr  <= 1'b0;
        end else if (i_cmd.act_send) begin
            if (r_c_hit) begin
                r_res[0]  <= mk_res(KIND_IPV4, r_c_mac, tag16(tag_st), 48'd0, 32'd0);
                r_res_cnt <= 2'd1;
            end else if (r_r_hit) begin
                r_res[0]  <= res_drop;
                r_res_cnt <= p_ok ? 2'd0 : 2'd1;
            end else if (!p_ok) begin
                r_res[0]  <= res_drop;
                r_res[1]  <= res_req;
                r_res_cnt <= 2'd2;
            end else begin
                r_res[0]  <= res_req;
                r_res[1]  <= res_drop;
                r_res_cnt <= r_r_free ? 2'd1 : 2'd2;
            end
        end else if (i_cmd.push_deliver) begin
            r_res[0]  <= mk_res(KIND_DELIVER, 48'd0, tag16(tag_st), 48'd0, 32'd0);
            r_res_cnt <= 2'd1;
        end else if (i_cmd.act_learn) begin
            if (r_p_hit) begin
                r_res[r_res_cnt[0]] <= mk_res(KIND_IPV4, lmac, tag16(r_p_tag), 48'd0, 32'd0);
                r_res_cnt           <= r_res_cnt + 2'd1;
            end
        end else if (i_cmd.push_reply) begin
            r_res[r_res_cnt[0]] <= mk_res(KIND_ARP_REPLY, r_item.sender_mac, 16'd0,
                                          r_item.sender_mac, r_item.sender_ip);
            r_res_cnt           <= r_res_cnt + 2'd1;
        end else if (i_cmd.out_pop) begin
            r_rd_ptr <= !r_rd_ptr;
        end
    end

endmodule

@@ rtl/are_ctrl.sv @@
// ============================================================================
// ARP resolution engine controller
// Sequences decode, table scans, table updates and result delivery.
// ============================================================================
`include "arp_resolution_engine_macros.svh"

module are_ctrl #(
    parameter int SCAN_LEN = 16,
    parameter int IW       = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  are_pkg::t_dp_sts i_sts,
    output are_pkg::t_dp_cmd o_cmd,
    output logic [IW-1:0]    o_scan_addr
);
    import are_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TICK,
        S_SCAN,
        S_TAIL,
        S_SEND,
        S_LEARN,
        S_REPLY,
        S_FINISH,
        S_OUT
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [IW-1:0] r_addr;
    logic [IW-1:0] n_addr;
    logic          r_second;
    logic          n_second;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_state == S_OUT;
    assign o_scan_addr = r_addr;

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_second = r_second;
        o_cmd    = '0;
        if (i_sts.action == ACT_SEND) begin
            o_cmd.key_sel = KEY_NHIP;
        end else begin
            o_cmd.key_sel = r_second ? KEY_TIP : KEY_SIP;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_addr   = '0;
                n_second = 1'b0;
                case (i_sts.action)
                    ACT_SEND: n_state = S_SCAN;
                    ACT_TICK: n_state = S_TICK;
                    ACT_RECV: begin
                        if (i_sts.rx_drop) begin
                            n_state = S_IDLE;
                        end else if (i_sts.rx_ipv4) begin
                            o_cmd.push_deliver = 1'b1;
                            n_state            = S_OUT;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_TICK: begin
                o_cmd.tick_add = 1'b1;
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd     = 1'b1;
                o_cmd.scan_expire = i_sts.action == ACT_TICK;
                if (r_addr == IW'(SCAN_LEN - 1)) begin
                    n_state = S_TAIL;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_TAIL: begin
                case (i_sts.action)
                    ACT_SEND: n_state = S_SEND;
                    ACT_RECV: n_state = S_LEARN;
                    default:  n_state = S_IDLE;
                endcase
            end
            S_SEND: begin
                o_cmd.act_send = 1'b1;
                n_state        = S_FINISH;
            end
            S_LEARN: begin
                o_cmd.act_learn = 1'b1;
                if (!r_second && i_sts.op_reply) begin
                    n_second = 1'b1;
                    n_addr   = '0;
                    n_state  = S_SCAN;
                end else if (!r_second && i_sts.op_request && i_sts.tip_own) begin
                    n_state = S_REPLY;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_REPLY: begin
                o_cmd.push_reply = 1'b1;
                n_state          = S_FINISH;
            end
            S_FINISH: begin
                n_state = (i_sts.res_cnt == '0) ? S_IDLE : S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    o_cmd.out_pop = 1'b1;
                    if (i_sts.out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_addr   <= '0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_second <= n_second;
        end
    end

    `ARE_ASSERT_IMP(a_ready_excl, o_in_ready, !o_out_valid, "ready while a result is offered")
    `ARE_ASSERT_NXT(a_accept_busy, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `ARE_ASSERT_NXT(a_last_ends, o_out_valid && i_out_ready && i_sts.out_last, !o_out_valid,
                    "result offered after last")

endmodule

@@ rtl/arp_resolution_engine.sv @@
// ARP resolution engine: one request in, zero to two result requests out. Every table
// access is a scan through the cache, pending and request tables together, one memory
// read per cycle over L entries (L is the largest table depth). A send, a tick and an
// ARP frame each take one scan, an ARP reply takes a second scan for the target, an ARP
// request for our IP adds a reply step, and an IPv4 or ignored frame takes no scan;
// results are then delivered one per accepted transfer. The next request is accepted
// only after the last result of the previous one is taken.
// Valid bits clear at reset, so there is no clearing pass.
// ============================================================================
// ARP resolution engine top level
// Stream ports, configuration port, controller and datapath.
// ============================================================================
module arp_resolution_engine #(
    parameter int CACHE_ENTRIES   = 16,
    parameter int PENDING_ENTRIES = 16,
    parameter int REQUEST_ENTRIES = 16,
    parameter int TAG_BITS        = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [1:0]                i_cfg_index,
    input  logic [are_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // next hop ip, datagram_tag, frame_dst_mac, ether_type, parse_ok, arp_opcode,
    // sender_mac, sender_ip, target_mac, target_ip, elapsed_ms, zero fill
    input  logic [are_pkg::ITEM_W-1:0] s_axis_tdata,
    // action
    input  logic [1:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // dst_mac, out_tag, reply_target_mac, reply_target_ip
    output logic [are_pkg::RES_W-1:0] m_axis_tdata,
    // kind
    output logic [2:0]                m_axis_tuser,
    output logic                      m_axis_tlast
);
    import are_pkg::*;

    localparam int SCAN_LEN = (CACHE_ENTRIES > PENDING_ENTRIES)
        ? ((CACHE_ENTRIES > REQUEST_ENTRIES) ? CACHE_ENTRIES : REQUEST_ENTRIES)
        : ((PENDING_ENTRIES > REQUEST_ENTRIES) ? PENDING_ENTRIES : REQUEST_ENTRIES);
    localparam int IW = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [IW-1:0] scan_addr;

    are_ctrl #(
        .SCAN_LEN (SCAN_LEN),
        .IW       (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_scan_addr (scan_addr)
    );

    are_dp #(
        .CACHE_ENTRIES   (CACHE_ENTRIES),
        .PENDING_ENTRIES (PENDING_ENTRIES),
        .REQUEST_ENTRIES (REQUEST_ENTRIES),
        .TAG_BITS        (TAG_BITS),
        .IW              (IW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_item_data   (s_axis_tdata),
        .i_item_action (s_axis_tuser),
        .i_cmd         (cmd),
        .i_scan_addr   (scan_addr),
        .o_sts         (sts),
        .o_res_data    (m_axis_tdata),
        .o_res_kind    (m_axis_tuser)
    );

    assign m_axis_tlast = sts.out_last;

endmodule

@@ sim/tb_arp_resolution_engine.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ARP resolution engine testbench
// Drives send, receive, tick and undefined-action requests through the stream port,
// predicts the ARP cache, pending and request-log state, and checks every result in order.
// ============================================================================
module tb_arp_resolution_engine;
    import are_pkg::*;

    localparam int NCACHE = 16;
    localparam int NPEND  = 16;
    localparam int NREQ   = 16;
    localparam int SETTLE = 200;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        t_result r;
        logic    last;
    } t_exp;

    typedef struct {
        logic [1:0] act;
        t_item      it;
        bit         typed;
        int         n;
        t_result    r;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [1:0]          i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [ITEM_W-1:0]   s_axis_tdata;
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [RES_W-1:0]    m_axis_tdata;
    logic [2:0]          m_axis_tuser;
    logic                m_axis_tlast;

    arp_resolution_engine u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // interface model state
    logic [47:0] mdl_own_mac;
    logic [31:0] mdl_own_ip;
    logic [31:0] mdl_lifetime;
    logic [31:0] mdl_holdoff;
    logic [63:0] mdl_now;
    bit          arp_vld [NCACHE];
    logic [31:0] arp_ip  [NCACHE];
    logic [47:0] arp_mac [NCACHE];
    logic [63:0] arp_exp [NCACHE];
    bit          park_vld [NPEND];
    logic [31:0] park_ip  [NPEND];
    logic [15:0] park_tag [NPEND];
    bit          rlog_vld [NREQ];
    logic [31:0] rlog_ip  [NREQ];
    logic [63:0] rlog_exp [NREQ];

    t_exp        frames_due [$];
    t_result     step_out [$];
    logic [31:0] ip_pool [40];
    int          mismatches;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          quiet_cycles;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? TIME_MAX : s[63:0];
    endfunction

    function automatic t_result mk_res(logic [2:0] k, logic [47:0] dst, logic [15:0] tag,
                                       logic [47:0] tmac, logic [31:0] tip);
        t_result r;
        r.kind = k;
        r.data.dst_mac = dst;
        r.data.out_tag = tag;
        r.data.reply_target_mac = tmac;
        r.data.reply_target_ip = tip;
        return r;
    endfunction

    function automatic int arp_lookup(logic [31:0] ip);
        for (int i = 0; i < NCACHE; i++)
            if (arp_vld[i] && arp_ip[i] == ip) return i;
        return -1;
    endfunction

    function automatic int park_lookup(logic [31:0] ip);
        for (int i = 0; i < NPEND; i++)
            if (park_vld[i] && park_ip[i] == ip) return i;
        return -1;
    endfunction

    task automatic arp_learn(logic [31:0] ip, logic [47:0] mac);
        int slot;
        slot = arp_lookup(ip);
        for (int i = 0; i < NCACHE && slot < 0; i++)
            if (!arp_vld[i]) slot = i;
        if (slot < 0) begin
            slot = 0;
            for (int i = 1; i < NCACHE; i++)
                if (arp_exp[i] < arp_exp[slot]) slot = i;
        end
        arp_vld[slot] = 1'b1;
        arp_ip[slot] = ip;
        arp_mac[slot] = mac;
        arp_exp[slot] = sat_add(mdl_now, {32'd0, mdl_lifetime});
    endtask

    task automatic park_flush(logic [31:0] ip, logic [47:0] mac);
        int p;
        p = park_lookup(ip);
        if (p >= 0) begin
            step_out.push_back(mk_res(KIND_IPV4, mac, park_tag[p], '0, '0));
            park_vld[p] = 1'b0;
        end
    endtask

    task automatic arp_send(t_item it);
        int  c;
        int  p;
        bit  dropped;
        bit  logged;
        dropped = 1'b0;
        logged = 1'b0;
        c = arp_lookup(it.gw_ip);
        if (c >= 0) begin
            step_out.push_back(mk_res(KIND_IPV4, arp_mac[c], it.datagram_tag, '0, '0));
            return;
        end
        p = park_lookup(it.gw_ip);
        for (int i = 0; i < NPEND && p < 0; i++)
            if (!park_vld[i]) p = i;
        if (p >= 0) begin
            park_vld[p] = 1'b1;
            park_ip[p] = it.gw_ip;
            park_tag[p] = it.datagram_tag;
        end else begin
            step_out.push_back(mk_res(KIND_DROP, '0, it.datagram_tag, '0, it.gw_ip));
            dropped = 1'b1;
        end
        for (int i = 0; i < NREQ; i++)
            if (rlog_vld[i] && rlog_ip[i] == it.gw_ip) return;
        step_out.push_back(mk_res(KIND_ARP_REQ, MAC_BCAST, '0, '0, it.gw_ip));
        for (int i = 0; i < NREQ && !logged; i++) begin
            if (!rlog_vld[i]) begin
                rlog_vld[i] = 1'b1;
                rlog_ip[i] = it.gw_ip;
                rlog_exp[i] = sat_add(mdl_now, {32'd0, mdl_holdoff});
                logged = 1'b1;
            end
        end
        if (!logged && !dropped)
            step_out.push_back(mk_res(KIND_DROP, '0, it.datagram_tag, '0, it.gw_ip));
    endtask

    task automatic arp_receive(t_item it);
        if (it.frame_dst_mac != mdl_own_mac && it.frame_dst_mac != MAC_BCAST) return;
        if (!it.parse_ok) return;
        if (it.ether_type == ET_IPV4) begin
            step_out.push_back(mk_res(KIND_DELIVER, '0, it.datagram_tag, '0, '0));
            return;
        end
        if (it.ether_type != ET_ARP) return;
        arp_learn(it.sender_ip, it.sender_mac);
        park_flush(it.sender_ip, it.sender_mac);
        if (it.arp_opcode == OP_REPLY) begin
            arp_learn(it.target_ip, it.target_mac);
            park_flush(it.target_ip, it.target_mac);
        end else if (it.arp_opcode == OP_REQUEST && it.target_ip == mdl_own_ip) begin
            step_out.push_back(mk_res(KIND_ARP_REPLY, it.sender_mac, '0, it.sender_mac,
                                      it.sender_ip));
        end
    endtask

    task automatic arp_tick(t_item it);
        mdl_now = sat_add(mdl_now, {32'd0, it.elapsed_ms});
        for (int i = 0; i < NCACHE; i++)
            if (arp_vld[i] && arp_exp[i] <= mdl_now) arp_vld[i] = 1'b0;
        for (int i = 0; i < NREQ; i++)
            if (rlog_vld[i] && rlog_exp[i] <= mdl_now) rlog_vld[i] = 1'b0;
    endtask

    task automatic resolve_step(logic [1:0] act, t_item it);
        step_out.delete();
        case (act)
            ACT_SEND: arp_send(it);
            ACT_RECV: arp_receive(it);
            ACT_TICK: arp_tick(it);
            default: ;
        endcase
    endtask

    task automatic queue_frames();
        t_exp e;
        foreach (step_out[i]) begin
            e.r = step_out[i];
            e.last = (i == step_out.size() - 1);
            frames_due.push_back(e);
        end
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        case (idx)
            REG_OWN_MAC:  mdl_own_mac = val[47:0];
            REG_OWN_IP:   mdl_own_ip = val[31:0];
            REG_LIFETIME: mdl_lifetime = val[31:0];
            default:      mdl_holdoff = val[31:0];
        endcase
    endtask

    task automatic drain();
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // present one request and hold it until it is accepted
    task automatic push_request(logic [1:0] act, t_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = it;
        s_axis_tuser = act;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic hold_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic t_item rand_item();
        t_item it;
        it.pad = '0;
        it.gw_ip = ip_pool[$urandom_range(39)];
        it.datagram_tag = 16'($urandom);
        it.frame_dst_mac = 48'({$urandom, $urandom});
        it.ether_type = 16'($urandom);
        it.parse_ok = ($urandom_range(99) < 90);
        it.arp_opcode = 16'($urandom);
        it.sender_mac = 48'({$urandom, $urandom});
        it.sender_ip = ip_pool[$urandom_range(39)];
        it.target_mac = 48'({$urandom, $urandom});
        it.target_ip = ip_pool[$urandom_range(39)];
        it.elapsed_ms = ($urandom_range(99) < 3) ? $urandom : $urandom_range(0, 3000);
        case ($urandom_range(99) / 10)
            0, 1, 2, 3, 4, 5, 6: it.frame_dst_mac = MAC_BCAST;
            7, 8: it.frame_dst_mac = mdl_own_mac;
            default: ;
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3, 4: it.ether_type = ET_ARP;
            5, 6, 7: it.ether_type = ET_IPV4;
            default: ;
        endcase
        case ($urandom_range(9))
            0, 1, 2, 3: it.arp_opcode = OP_REPLY;
            4, 5, 6, 7: it.arp_opcode = OP_REQUEST;
            default: ;
        endcase
        if ($urandom_range(99) < 30) it.target_ip = mdl_own_ip;
        return it;
    endfunction

    function automatic logic [1:0] rand_action();
        int r;
        r = $urandom_range(99);
        if (r < 40) return ACT_SEND;
        if (r < 85) return ACT_RECV;
        if (r < 97) return ACT_TICK;
        return 2'd3;
    endfunction

    task automatic run_random(int count);
        logic [1:0] act;
        t_item      it;
        for (int n = 0; n < count; n++) begin
            act = rand_action();
            it = rand_item();
            push_request(act, it);
            resolve_step(act, it);
            queue_frames();
            if (n == count / 2) begin
                hold_idle();
                while (frames_due.size() != 0) @(posedge i_clk);
            end
        end
        hold_idle();
    endtask

    function automatic t_row mk_row(logic [1:0] act, t_item it, bit typed, int n,
                                    t_result r);
        t_row row;
        row.act = act;
        row.it = it;
        row.typed = typed;
        row.n = n;
        row.r = r;
        return row;
    endfunction

    task automatic run_directed();
        t_row    rows [$];
        t_item   base;
        t_item   it;
        t_result none;
        t_exp    e;
        none = '0;
        base = '0;
        base.parse_ok = 1'b1;
        base.frame_dst_mac = MAC_BCAST;

        it = base; it.gw_ip = 32'h0A00_0001; it.datagram_tag = 16'h0001;
        rows.push_back(mk_row(ACT_SEND, it, 1'b1, 1,
                              mk_res(KIND_ARP_REQ, MAC_BCAST, '0, '0, 32'h0A00_0001)));
        it = base; it.frame_dst_mac = 48'h1234_5678_9ABC; it.ether_type = ET_IPV4;
        rows.push_back(mk_row(ACT_RECV, it, 1'b1, 0, none));
        it = '1; it.pad = '0; it.frame_dst_mac = MAC_BCAST; it.ether_type = ET_IPV4;
        rows.push_back(mk_row(ACT_RECV, it, 1'b1, 1,
                              mk_res(KIND_DELIVER, '0, 16'hFFFF, '0, '0)));
        it = base; it.ether_type = ET_IPV4; it.parse_ok = 1'b0;
        rows.push_back(mk_row(ACT_RECV, it, 1'b1, 0, none));
        it = base; it.ether_type = 16'h86DD;
        rows.push_back(mk_row(ACT_RECV, it, 1'b1, 0, none));
        it = '1; it.pad = '0; it.frame_dst_mac = MAC_BCAST; it.ether_type = ET_ARP;
        rows.push_back(mk_row(ACT_RECV, it, 1'b0, 0, none));
        it = base; it.ether_type = ET_ARP; it.arp_opcode = OP_REPLY;
        it.sender_ip = 32'h0A00_0001; it.sender_mac = 48'h0200_0000_0001;
        it.target_ip = 32'h0A00_0002; it.target_mac = 48'h0200_0000_0002;
        rows.push_back(mk_row(ACT_RECV, it, 1'b0, 0, none));
        it = base; it.ether_type = ET_ARP; it.arp_opcode = OP_REQUEST;
        it.sender_ip = 32'hC0A8_0001; it.sender_mac = 48'hFFFF_FFFF_FFFE;
        it.target_ip = 32'h0;
        rows.push_back(mk_row(ACT_RECV, it, 1'b0, 0, none));
        it = base; it.frame_dst_mac = '0; it.ether_type = ET_ARP; it.arp_opcode = OP_REQUEST;
        it.sender_ip = 32'hFFFF_FFFF; it.target_ip = 32'h1;
        rows.push_back(mk_row(ACT_RECV, it, 1'b0, 0, none));
        it = base; it.gw_ip = 32'h0A00_0001; it.datagram_tag = 16'hBEEF;
        rows.push_back(mk_row(ACT_SEND, it, 1'b0, 0, none));
        it = base; it.gw_ip = 32'h0; it.datagram_tag = 16'h0;
        rows.push_back(mk_row(ACT_SEND, it, 1'b0, 0, none));
        it = base; it.gw_ip = 32'h0A00_0009; it.datagram_tag = 16'h0009;
        rows.push_back(mk_row(ACT_SEND, it, 1'b0, 0, none));
        it = base; it.gw_ip = 32'h0A00_0009; it.datagram_tag = 16'h0019;
        rows.push_back(mk_row(ACT_SEND, it, 1'b0, 0, none));
        it = '1; it.pad = '0;
        rows.push_back(mk_row(2'd3, it, 1'b1, 0, none));
        it = base; it.elapsed_ms = 32'd4999;
        rows.push_back(mk_row(ACT_TICK, it, 1'b1, 0, none));
        it = base; it.gw_ip = 32'h0A00_0009; it.datagram_tag = 16'h0029;
        rows.push_back(mk_row(ACT_SEND, it, 1'b0, 0, none));
        it = base; it.elapsed_ms = 32'd1;
        rows.push_back(mk_row(ACT_TICK, it, 1'b1, 0, none));
        it = base; it.gw_ip = 32'h0A00_0009; it.datagram_tag = 16'h0039;
        rows.push_back(mk_row(ACT_SEND, it, 1'b0, 0, none));
        it = base; it.ether_type = ET_ARP; it.arp_opcode = 16'hFFFF;
        it.sender_ip = 32'h0A00_0009; it.sender_mac = 48'h0200_0000_0009;
        rows.push_back(mk_row(ACT_RECV, it, 1'b0, 0, none));
        it = base; it.elapsed_ms = 32'hFFFF_FFFF;
        rows.push_back(mk_row(ACT_TICK, it, 1'b1, 0, none));
        it = base; it.gw_ip = 32'h0A00_0001; it.datagram_tag = 16'h7777;
        rows.push_back(mk_row(ACT_SEND, it, 1'b0, 0, none));

        foreach (rows[i]) begin
            push_request(rows[i].act, rows[i].it);
            resolve_step(rows[i].act, rows[i].it);
            if (rows[i].typed) begin
                if (rows[i].n != 0) begin
                    e.r = rows[i].r;
                    e.last = 1'b1;
                    frames_due.push_back(e);
                end
            end else begin
                queue_frames();
            end
        end
        hold_idle();
    endtask

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge i_clk) begin
        t_exp      e;
        t_res_data d;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            d = m_axis_tdata;
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d data=%h", m_axis_tuser, m_axis_tdata);
            end else begin
                e = frames_due.pop_front();
                if (m_axis_tuser !== e.r.kind || d.dst_mac !== e.r.data.dst_mac
                    || d.out_tag !== e.r.data.out_tag
                    || d.reply_target_mac !== e.r.data.reply_target_mac
                    || d.reply_target_ip !== e.r.data.reply_target_ip
                    || m_axis_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp kind=%0d data=%h last=%b got kind=%0d data=%h last=%b",
                                 e.r.kind, e.r.data, e.last, m_axis_tuser, m_axis_tdata,
                                 m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        quiet_cycles = 0;
        src_idle_pct = 21;
        snk_idle_pct = 70;
        mdl_own_mac = '0;
        mdl_own_ip = '0;
        mdl_lifetime = 32'd30000;
        mdl_holdoff = 32'd5000;
        mdl_now = '0;
        foreach (arp_vld[i]) arp_vld[i] = 1'b0;
        foreach (park_vld[i]) park_vld[i] = 1'b0;
        foreach (rlog_vld[i]) rlog_vld[i] = 1'b0;
        foreach (ip_pool[i]) ip_pool[i] = $urandom;
        ip_pool[0] = 32'h0;
        ip_pool[1] = 32'hFFFF_FFFF;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        drain();

        cfg_write(REG_OWN_MAC, 48'({$urandom, $urandom}));
        cfg_write(REG_OWN_IP, 48'(ip_pool[2]));
        cfg_write(REG_LIFETIME, 48'd1);
        cfg_write(REG_HOLDOFF, 48'hFFFF_FFFF);
        run_random(200);
        drain();

        cfg_write(REG_OWN_MAC, MAC_BCAST);
        cfg_write(REG_OWN_IP, 48'hFFFF_FFFF);
        cfg_write(REG_LIFETIME, 48'hFFFF_FFFF);
        cfg_write(REG_HOLDOFF, 48'd1);
        run_random(450);
        drain();

        src_idle_pct = 70;
        snk_idle_pct = 21;
        cfg_write(REG_OWN_MAC, 48'({$urandom, $urandom}));
        cfg_write(REG_OWN_IP, 48'h0);
        cfg_write(REG_LIFETIME, 48'd30000);
        cfg_write(REG_HOLDOFF, 48'd5000);
        run_random(650);
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        cfg_write(REG_OWN_IP, 48'(ip_pool[3]));
        cfg_write(REG_LIFETIME, 48'd8000);
        cfg_write(REG_HOLDOFF, 48'd2500);
        run_random(630);
        drain();

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
